FILE: hdl/isq_pkg.sv
// Package for the interval stabbing query block: types, codes and defaults.
package isq_pkg;

  localparam int unsigned TableDepthDef = 1024;
  localparam int unsigned MaxHitsDef    = 32;
  localparam int unsigned IdxW          = 10;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_HIT  = 2'd0,
    ST_MISS = 2'd1,
    ST_OK   = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_SORT,
    S_EMIT,
    S_REPLY
  } fsm_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] reference_id;
    logic [31:0] interval_start;
    logic [31:0] interval_end;
    logic [7:0]  interval_layer;
    logic [31:0] query_pos;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  hit_index;
    logic [31:0] hit_start;
    logic [31:0] hit_end;
    logic [7:0]  hit_layer;
    logic        last;
  } out_item_t;

endpackage

FILE: hdl/isq_if.sv
// Valid/ready channel interfaces for input items and result items.
interface isq_in_if;
  logic               valid;
  logic               ready;
  isq_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface isq_out_if;
  logic               valid;
  logic               ready;
  isq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/interval_stabbing_query.sv
// Top level of the interval stabbing query block.
//
//  channel | dir | handshake        | payload
//  in_     | in  | in.valid/ready   | req_type, reference_id, start, end, layer, pos
//  out_    | out | out.valid/ready  | status, hit_index, hit_start, hit_end, hit_layer, last
//
// Clear and insert take the input beat, then one result beat. A query reads one table
// entry per cycle from the entry memory over entries 0 to entry_count - 1, drains the
// last read, runs one odd-even compare-and-swap pass per kept hit (at most MAX_HITS),
// then gives one result beat per hit, or a miss beat if none. Reset is synchronous (rst_n
// low) and clears the entry count and control state; memory contents are undefined
// until written. A stalled result beat holds the block; one input item is in work at a time.
module interval_stabbing_query #(
  parameter int unsigned TABLE_DEPTH = isq_pkg::TableDepthDef,
  parameter int unsigned MAX_HITS    = isq_pkg::MaxHitsDef
) (
  input logic clk,
  input logic rst_n,
  isq_in_if.sink    in_ch,
  isq_out_if.source out_ch
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned NW = $clog2(MAX_HITS + 1);

  typedef struct packed {
    logic [AW-1:0] idx;
    logic [31:0]   s;
    logic [31:0]   e;
    logic [7:0]    layer;
  } hit_t;

  // entry memory, one word per entry
  logic [103:0] mem [TABLE_DEPTH];
  logic [103:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic          ins_wr;

  isq_pkg::fsm_t state_r, state_nxt;
  isq_pkg::in_item_t item_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] scan_r, scan_nxt;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  hit_t          hits_r [MAX_HITS];
  logic [NW-1:0] nsel_r;
  logic [NW-1:0] pass_r;
  logic [NW-1:0] emit_r;
  isq_pkg::status_t reply_r;

  always_ff @(posedge clk) begin
    if (ins_wr) begin
      mem[count_r[AW-1:0]] <= {item_r.reference_id, item_r.interval_start,
                               item_r.interval_end, item_r.interval_layer};
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_addr = scan_r[AW-1:0];
  assign ins_wr  = (state_r == isq_pkg::S_REPLY) && out_ch.ready &&
                   (reply_r == isq_pkg::ST_OK) && (item_r.req_type == isq_pkg::REQ_INSERT);

  // key order (start, end, index)
  function automatic logic key_after(hit_t a, hit_t b);
    if (a.s != b.s) return a.s > b.s;
    if (a.e != b.e) return a.e > b.e;
    return a.idx > b.idx;
  endfunction

  function automatic logic ranks_before(hit_t a, hit_t b);
    if (a.layer != b.layer) return a.layer > b.layer;
    return key_after(a, b);
  endfunction

  // scanned entry as a candidate
  hit_t cand;
  logic cand_match;
  always_comb begin
    cand.idx   = rd_idx_r;
    cand.s     = rd_q[71:40];
    cand.e     = rd_q[39:8];
    cand.layer = rd_q[7:0];
    cand_match = rd_vld_r && (rd_q[103:72] == item_r.reference_id) &&
                 (cand.s <= item_r.query_pos) && (item_r.query_pos < cand.e);
  end

  // hit list kept sorted by key descending; insert candidate, drop the smallest
  logic [MAX_HITS-1:0] gt;
  always_comb begin
    for (int k = 0; k < MAX_HITS; k++) begin
      gt[k] = (NW'(k) >= nsel_r) || key_after(cand, hits_r[k]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isq_pkg::S_IDLE:  if (in_ch.valid) begin
        priority if (in_ch.data.req_type == isq_pkg::REQ_QUERY) state_nxt = isq_pkg::S_SCAN;
        else if (in_ch.data.req_type == isq_pkg::REQ_NONE)     state_nxt = isq_pkg::S_IDLE;
        else                                                   state_nxt = isq_pkg::S_REPLY;
      end
      isq_pkg::S_SCAN:  if (scan_r >= count_r) state_nxt = isq_pkg::S_DRAIN;
      isq_pkg::S_DRAIN: if (!rd_vld_r) state_nxt = (nsel_r == '0) ? isq_pkg::S_REPLY
                                                                   : isq_pkg::S_SORT;
      isq_pkg::S_SORT:  if (pass_r + 1'b1 >= nsel_r) state_nxt = isq_pkg::S_EMIT;
      isq_pkg::S_EMIT:  if (out_ch.ready && emit_r + 1'b1 == nsel_r) state_nxt = isq_pkg::S_IDLE;
      isq_pkg::S_REPLY: if (out_ch.ready) state_nxt = isq_pkg::S_IDLE;
      default:          state_nxt = isq_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready  = (state_r == isq_pkg::S_IDLE);
    out_ch.valid = (state_r == isq_pkg::S_EMIT) || (state_r == isq_pkg::S_REPLY);
    out_ch.data  = '0;
    out_ch.data.last = 1'b1;
    if (state_r == isq_pkg::S_EMIT) begin
      out_ch.data.status    = isq_pkg::ST_HIT;
      out_ch.data.hit_index = 10'(hits_r[emit_r[HW-1:0]].idx);
      out_ch.data.hit_start = hits_r[emit_r[HW-1:0]].s;
      out_ch.data.hit_end   = hits_r[emit_r[HW-1:0]].e;
      out_ch.data.hit_layer = hits_r[emit_r[HW-1:0]].layer;
      out_ch.data.last      = (emit_r + 1'b1 == nsel_r);
    end else begin
      out_ch.data.status = reply_r;
    end
  end

  // count and scan pointer
  always_comb begin
    count_nxt = count_r;
    scan_nxt  = scan_r;
    if (state_r == isq_pkg::S_IDLE && in_ch.valid) begin
      scan_nxt = '0;
      if (in_ch.data.req_type == isq_pkg::REQ_CLEAR) count_nxt = '0;
    end
    if (state_r == isq_pkg::S_SCAN && scan_r < count_r) scan_nxt = scan_r + 1'b1;
    if (ins_wr) count_nxt = count_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= isq_pkg::S_IDLE;
      count_r  <= '0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      nsel_r   <= '0;
      pass_r   <= '0;
      emit_r   <= '0;
      reply_r  <= isq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      scan_r   <= scan_nxt;
      rd_vld_r <= (state_r == isq_pkg::S_SCAN) && (scan_r < count_r);
      rd_idx_r <= scan_r[AW-1:0];
      if (state_r == isq_pkg::S_IDLE && in_ch.valid) begin
        item_r <= in_ch.data;
        nsel_r <= '0;
        pass_r <= '0;
        emit_r <= '0;
        if (in_ch.data.req_type == isq_pkg::REQ_INSERT && count_r >= CW'(TABLE_DEPTH))
          reply_r <= isq_pkg::ST_FULL;
        else if (in_ch.data.req_type == isq_pkg::REQ_QUERY)
          reply_r <= isq_pkg::ST_MISS;
        else
          reply_r <= isq_pkg::ST_OK;
      end
      // sorted insert of a matching entry
      if (cand_match && (nsel_r < NW'(MAX_HITS) || gt[MAX_HITS-1])) begin
        if (gt[0]) hits_r[0] <= cand;
        for (int k = 1; k < MAX_HITS; k++) begin
          if (gt[k]) hits_r[k] <= gt[k-1] ? hits_r[k-1] : cand;
        end
        if (nsel_r < NW'(MAX_HITS)) nsel_r <= nsel_r + 1'b1;
      end
      // one odd-even compare-and-swap pass per cycle, by rank
      if (state_r == isq_pkg::S_SORT) begin
        for (int k = 0; k + 1 < MAX_HITS; k++) begin
          if ((((k % 2) == 1) == pass_r[0]) && (NW'(k + 1) < nsel_r) &&
              ranks_before(hits_r[k + 1], hits_r[k])) begin
            hits_r[k]     <= hits_r[k + 1];
            hits_r[k + 1] <= hits_r[k];
          end
        end
        pass_r <= pass_r + 1'b1;
      end
      if (state_r == isq_pkg::S_EMIT && out_ch.ready) emit_r <= emit_r + 1'b1;
    end
  end

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH)) else $error("entry count over depth");
  a_nsel_max: assert property (@(posedge clk) disable iff (!rst_n)
    nsel_r <= NW'(MAX_HITS)) else $error("hit list overflow");
  a_emit_rng: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == isq_pkg::S_EMIT |-> emit_r < nsel_r) else $error("emit beyond hits");
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken during result");

endmodule
